>>> rtl/core/tauv_pkg.sv
// ----------------------------------------------------------------------------
// tauv_pkg: shared definitions for the affine triangle UV mapper
// Default word size, configuration register indexes and the per-axis
// control word that travels alongside each word in the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tauv_pkg;

  // Default coordinate word width (Q16.16 words).
  localparam int COORD_BITS_DEF = 32;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER0_XY = 3'd0,
    REG_CORNER1_XY = 3'd1,
    REG_CORNER2_XY = 3'd2,
    REG_CORNER0_UV = 3'd3,
    REG_CORNER1_UV = 3'd4,
    REG_CORNER2_UV = 3'd5
  } cfg_reg_t;

  // Per-axis control bits: collinear corners, and sign of the quotient.
  typedef struct packed {
    logic deg;
    logic neg;
  } axis_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/tauv_front.sv
// ----------------------------------------------------------------------------
// tauv_front: determinant and numerator pipeline
// Seven register stages form the corner differences, the 2x2 determinant,
// the barycentric terms and the per-axis numerators, and hand magnitudes
// and signs to the dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tauv_front #(
  parameter int CW = tauv_pkg::COORD_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire logic signed [CW-1:0]  in_point_x,
  input  wire logic signed [CW-1:0]  in_point_y,
  input  wire logic [2:0][2*CW-1:0]  cfg_xy,
  input  wire logic [2:0][2*CW-1:0]  cfg_uv,
  output logic                       out_valid,
  output logic [3*CW+4:0]            out_nm_u,
  output logic [3*CW+4:0]            out_nm_v,
  output logic [2*CW+2:0]            out_dm,
  output tauv_pkg::axis_ctl_t        out_ctl_u,
  output tauv_pkg::axis_ctl_t        out_ctl_v,
  output logic signed [CW-1:0]       out_c0_u,
  output logic signed [CW-1:0]       out_c0_v
);

  localparam int DW  = CW + 1;       // difference width
  localparam int PW  = 2 * DW;       // product width
  localparam int SW  = PW + 1;       // determinant and s, t width
  localparam int LW  = DW;           // low split of s and t
  localparam int HW  = SW - LW;      // signed high split of s and t
  localparam int PHW = DW + HW;
  localparam int PLW = DW + LW + 1;
  localparam int TW  = DW + SW;      // one numerator term
  localparam int NW  = TW + 1;       // numerator

  // Corner words from the configuration registers.
  logic signed [CW-1:0] x0, y0, x1, y1, x2, y2, u0, v0, u1, v1, u2, v2;
  assign x0 = cfg_xy[0][2*CW-1:CW];
  assign y0 = cfg_xy[0][CW-1:0];
  assign x1 = cfg_xy[1][2*CW-1:CW];
  assign y1 = cfg_xy[1][CW-1:0];
  assign x2 = cfg_xy[2][2*CW-1:CW];
  assign y2 = cfg_xy[2][CW-1:0];
  assign u0 = cfg_uv[0][2*CW-1:CW];
  assign v0 = cfg_uv[0][CW-1:0];
  assign u1 = cfg_uv[1][2*CW-1:CW];
  assign v1 = cfg_uv[1][CW-1:0];
  assign u2 = cfg_uv[2][2*CW-1:CW];
  assign v2 = cfg_uv[2][CW-1:0];

  logic [7:1] vld_r;

  // Stage 1: differences against corner 0.
  logic signed [DW-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r, s1_qx_r, s1_qy_r;
  logic signed [DW-1:0] du1_r [1:3];
  logic signed [DW-1:0] du2_r [1:3];
  logic signed [DW-1:0] dv1_r [1:3];
  logic signed [DW-1:0] dv2_r [1:3];
  logic signed [CW-1:0] c0u_r [1:7];
  logic signed [CW-1:0] c0v_r [1:7];

  always_ff @(posedge clk) begin
    s1_ax_r  <= DW'(x1) - DW'(x0);
    s1_ay_r  <= DW'(y1) - DW'(y0);
    s1_bx_r  <= DW'(x2) - DW'(x0);
    s1_by_r  <= DW'(y2) - DW'(y0);
    s1_qx_r  <= DW'(in_point_x) - DW'(x0);
    s1_qy_r  <= DW'(in_point_y) - DW'(y0);
    du1_r[1] <= DW'(u1) - DW'(u0);
    du2_r[1] <= DW'(u2) - DW'(u0);
    dv1_r[1] <= DW'(v1) - DW'(v0);
    dv2_r[1] <= DW'(v2) - DW'(v0);
    c0u_r[1] <= u0;
    c0v_r[1] <= v0;
    for (int k = 2; k <= 3; k++) begin
      du1_r[k] <= du1_r[k-1];
      du2_r[k] <= du2_r[k-1];
      dv1_r[k] <= dv1_r[k-1];
      dv2_r[k] <= dv2_r[k-1];
    end
    for (int k = 2; k <= 7; k++) begin
      c0u_r[k] <= c0u_r[k-1];
      c0v_r[k] <= c0v_r[k-1];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:1], in_valid};
    end
  end

  // Stage 2: cross products.
  logic signed [PW-1:0] s2_aby_r, s2_bay_r, s2_qby_r, s2_qybx_r, s2_aqy_r, s2_ayqx_r;

  always_ff @(posedge clk) begin
    s2_aby_r  <= s1_ax_r * s1_by_r;
    s2_bay_r  <= s1_bx_r * s1_ay_r;
    s2_qby_r  <= s1_qx_r * s1_by_r;
    s2_qybx_r <= s1_qy_r * s1_bx_r;
    s2_aqy_r  <= s1_ax_r * s1_qy_r;
    s2_ayqx_r <= s1_ay_r * s1_qx_r;
  end

  // Stage 3: determinant and the two barycentric terms.
  logic signed [SW-1:0] s3_d_r, s3_s_r, s3_t_r;

  always_ff @(posedge clk) begin
    s3_d_r <= SW'(s2_aby_r) - SW'(s2_bay_r);
    s3_s_r <= SW'(s2_qby_r) - SW'(s2_qybx_r);
    s3_t_r <= SW'(s2_aqy_r) - SW'(s2_ayqx_r);
  end

  // Stage 4: split products of the parameter deltas with s and t,
  // and the magnitude of the determinant.
  logic signed [HW-1:0] s_hi, t_hi;
  logic signed [LW:0]   s_lo, t_lo;
  assign s_hi = s3_s_r[SW-1:LW];
  assign t_hi = s3_t_r[SW-1:LW];
  assign s_lo = $signed({1'b0, s3_s_r[LW-1:0]});
  assign t_lo = $signed({1'b0, s3_t_r[LW-1:0]});

  logic signed [PHW-1:0] s4_u1h_r, s4_u2h_r, s4_v1h_r, s4_v2h_r;
  logic signed [PLW-1:0] s4_u1l_r, s4_u2l_r, s4_v1l_r, s4_v2l_r;
  logic [SW-1:0]         dm_r [4:7];
  logic [7:4]            deg_r;
  logic [7:4]            dneg_r;

  always_ff @(posedge clk) begin
    s4_u1h_r  <= du1_r[3] * s_hi;
    s4_u1l_r  <= du1_r[3] * s_lo;
    s4_u2h_r  <= du2_r[3] * t_hi;
    s4_u2l_r  <= du2_r[3] * t_lo;
    s4_v1h_r  <= dv1_r[3] * s_hi;
    s4_v1l_r  <= dv1_r[3] * s_lo;
    s4_v2h_r  <= dv2_r[3] * t_hi;
    s4_v2l_r  <= dv2_r[3] * t_lo;
    dm_r[4]   <= s3_d_r[SW-1] ? SW'(-s3_d_r) : SW'(s3_d_r);
    deg_r[4]  <= (s3_d_r == '0);
    dneg_r[4] <= s3_d_r[SW-1];
    for (int k = 5; k <= 7; k++) begin
      dm_r[k]   <= dm_r[k-1];
      deg_r[k]  <= deg_r[k-1];
      dneg_r[k] <= dneg_r[k-1];
    end
  end

  // Stage 5: recombine the split products.
  logic signed [TW-1:0] s5_u1_r, s5_u2_r, s5_v1_r, s5_v2_r;

  always_ff @(posedge clk) begin
    s5_u1_r <= (TW'(s4_u1h_r) <<< LW) + TW'(s4_u1l_r);
    s5_u2_r <= (TW'(s4_u2h_r) <<< LW) + TW'(s4_u2l_r);
    s5_v1_r <= (TW'(s4_v1h_r) <<< LW) + TW'(s4_v1l_r);
    s5_v2_r <= (TW'(s4_v2h_r) <<< LW) + TW'(s4_v2l_r);
  end

  // Stage 6: per-axis numerators.
  logic signed [NW-1:0] s6_nu_r, s6_nv_r;

  always_ff @(posedge clk) begin
    s6_nu_r <= NW'(s5_u1_r) + NW'(s5_u2_r);
    s6_nv_r <= NW'(s5_v1_r) + NW'(s5_v2_r);
  end

  // Stage 7: numerator magnitudes and quotient signs.
  logic [NW-1:0] s7_nmu_r, s7_nmv_r;
  logic          s7_negu_r, s7_negv_r;

  always_ff @(posedge clk) begin
    s7_nmu_r  <= s6_nu_r[NW-1] ? NW'(-s6_nu_r) : NW'(s6_nu_r);
    s7_nmv_r  <= s6_nv_r[NW-1] ? NW'(-s6_nv_r) : NW'(s6_nv_r);
    s7_negu_r <= s6_nu_r[NW-1] ^ dneg_r[6];
    s7_negv_r <= s6_nv_r[NW-1] ^ dneg_r[6];
  end

  assign out_valid     = vld_r[7];
  assign out_nm_u      = s7_nmu_r;
  assign out_nm_v      = s7_nmv_r;
  assign out_dm        = dm_r[7];
  assign out_ctl_u.deg = deg_r[7];
  assign out_ctl_u.neg = s7_negu_r;
  assign out_ctl_v.deg = deg_r[7];
  assign out_ctl_v.neg = s7_negv_r;
  assign out_c0_u      = c0u_r[7];
  assign out_c0_v      = c0v_r[7];

endmodule

`default_nettype wire

>>> rtl/core/tauv_div.sv
// ----------------------------------------------------------------------------
// tauv_div: pipelined restoring divider
// Forms twice the numerator over the divisor, one quotient bit per stage,
// and flags quotients too large for the quotient width.
// ----------------------------------------------------------------------------
`default_nettype none

module tauv_div #(
  parameter int CW  = tauv_pkg::COORD_BITS_DEF,
  parameter int NW  = 3 * CW + 5,
  parameter int DVW = 2 * CW + 3,
  parameter int QB  = CW + 2
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire logic [NW-1:0]         in_num,
  input  wire logic [DVW-1:0]        in_den,
  input  wire tauv_pkg::axis_ctl_t   in_ctl,
  input  wire logic signed [CW-1:0]  in_c0,
  output logic                       out_valid,
  output logic [QB-1:0]              out_quo,
  output logic                       out_ovf,
  output tauv_pkg::axis_ctl_t        out_ctl,
  output logic signed [CW-1:0]       out_c0
);

  localparam int RW0 = NW + 1 - QB;

  // Twice the numerator; the part above the quotient bits must stay
  // below the divisor or the quotient does not fit.
  logic [NW:0]     numer;
  logic [RW0-1:0]  top_bits;
  logic            ovf_nxt;
  assign numer    = {in_num, 1'b0};
  assign top_bits = numer[NW:QB];
  assign ovf_nxt  = (top_bits >= RW0'(in_den));

  logic [QB:0]               vld_r;
  logic [QB:0]               ovf_r;
  logic [DVW-1:0]            rem_r [QB+1];
  logic [DVW-1:0]            den_r [QB+1];
  logic [QB-1:0]             lo_r  [QB+1];
  logic [QB-1:0]             quo_r [QB+1];
  tauv_pkg::axis_ctl_t       ctl_r [QB+1];
  logic signed [CW-1:0]      c0_r  [QB+1];

  // Entry stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r[0] <= ovf_nxt;
    rem_r[0] <= top_bits[DVW-1:0];
    den_r[0] <= in_den;
    lo_r[0]  <= numer[QB-1:0];
    quo_r[0] <= '0;
    ctl_r[0] <= in_ctl;
    c0_r[0]  <= in_c0;
  end

  // One quotient bit per stage.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DVW:0] trial;
    logic         ge;
    assign trial = {rem_r[k], lo_r[k][QB-1]};
    assign ge    = (trial >= {1'b0, den_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? DVW'(trial - {1'b0, den_r[k]}) : trial[DVW-1:0];
      den_r[k+1] <= den_r[k];
      lo_r[k+1]  <= lo_r[k] << 1;
      quo_r[k+1] <= {quo_r[k][QB-2:0], ge};
      ovf_r[k+1] <= ovf_r[k];
      ctl_r[k+1] <= ctl_r[k];
      c0_r[k+1]  <= c0_r[k];
    end
  end

  assign out_valid = vld_r[QB];
  assign out_quo   = quo_r[QB];
  assign out_ovf   = ovf_r[QB];
  assign out_ctl   = ctl_r[QB];
  assign out_c0    = c0_r[QB];

endmodule

`default_nettype wire

>>> rtl/core/triangle_affine_uv_map_core.sv
// ----------------------------------------------------------------------------
// triangle_affine_uv_map_core: affine map from triangle corners to UV
// Maps each point through the affine transform fixed by three corner
// positions and their UV parameters, with rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six corner registers through cfg_we, cfg_index and cfg_wdata
//   while no point is in flight; each write lands at the clock edge.
//   A point word is taken at each edge where start is high and busy is low.
//   busy is low whenever reset is released, so one point per cycle is taken.
//   Each result word appears on the out_ ports for one cycle with out_valid
//   high, after its point has passed seven stages of products and numerators,
//   one divider entry stage, COORD_BITS + 2 divider stages of one quotient
//   bit each, and three stages of rounding, offset and clipping.
//   The receiver cannot stall; results leave in point order.
//   Collinear corners give zero UV with out_degenerate set.
//   Synchronous reset clears the corner registers and all valid bits, and
//   holds busy high so no point is taken during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_affine_uv_map_core #(
  parameter int COORD_BITS = tauv_pkg::COORD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire logic signed [COORD_BITS-1:0]    in_point_x,
  input  wire logic signed [COORD_BITS-1:0]    in_point_y,
  output logic                                 out_valid,
  output logic signed [COORD_BITS-1:0]         out_param_u,
  output logic signed [COORD_BITS-1:0]         out_param_v,
  output logic                                 out_degenerate,
  output logic                                 out_saturated,
  input  wire                                  cfg_we,
  input  wire logic [tauv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [2*COORD_BITS-1:0]         cfg_wdata
);

  localparam int CW  = COORD_BITS;
  localparam int SW  = 2 * (CW + 1) + 1;
  localparam int NW  = (CW + 1) + SW + 1;
  localparam int QB  = CW + 2;
  localparam int VW  = CW + 3;

  localparam logic signed [VW-1:0] HI_LIM = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] LO_LIM = ~HI_LIM;
  localparam logic [CW-1:0]        OUT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        OUT_MIN = {1'b1, {(CW-1){1'b0}}};

  // No point is taken during reset.
  assign busy = !rst_n;

  // Corner registers.
  logic [2:0][2*CW-1:0] cfg_xy_r, cfg_uv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_xy_r <= '0;
      cfg_uv_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tauv_pkg::REG_CORNER0_XY: begin
          cfg_xy_r[0] <= cfg_wdata;
        end
        tauv_pkg::REG_CORNER1_XY: begin
          cfg_xy_r[1] <= cfg_wdata;
        end
        tauv_pkg::REG_CORNER2_XY: begin
          cfg_xy_r[2] <= cfg_wdata;
        end
        tauv_pkg::REG_CORNER0_UV: begin
          cfg_uv_r[0] <= cfg_wdata;
        end
        tauv_pkg::REG_CORNER1_UV: begin
          cfg_uv_r[1] <= cfg_wdata;
        end
        tauv_pkg::REG_CORNER2_UV: begin
          cfg_uv_r[2] <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Determinant and numerator pipeline.
  logic                 fr_valid;
  logic [NW-1:0]        fr_nm [2];
  logic [SW-1:0]        fr_dm;
  tauv_pkg::axis_ctl_t  fr_ctl [2];
  logic signed [CW-1:0] fr_c0 [2];

  tauv_front #(
    .CW (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .cfg_xy     (cfg_xy_r),
    .cfg_uv     (cfg_uv_r),
    .out_valid  (fr_valid),
    .out_nm_u   (fr_nm[0]),
    .out_nm_v   (fr_nm[1]),
    .out_dm     (fr_dm),
    .out_ctl_u  (fr_ctl[0]),
    .out_ctl_v  (fr_ctl[1]),
    .out_c0_u   (fr_c0[0]),
    .out_c0_v   (fr_c0[1])
  );

  // One divider lane per axis.
  logic [1:0]           dv_valid;
  logic [QB-1:0]        dv_quo [2];
  logic [1:0]           dv_ovf;
  tauv_pkg::axis_ctl_t  dv_ctl [2];
  logic signed [CW-1:0] dv_c0 [2];

  for (genvar a = 0; a < 2; a++) begin : g_lane
    tauv_div #(
      .CW  (CW),
      .NW  (NW),
      .DVW (SW),
      .QB  (QB)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (fr_valid),
      .in_num    (fr_nm[a]),
      .in_den    (fr_dm),
      .in_ctl    (fr_ctl[a]),
      .in_c0     (fr_c0[a]),
      .out_valid (dv_valid[a]),
      .out_quo   (dv_quo[a]),
      .out_ovf   (dv_ovf[a]),
      .out_ctl   (dv_ctl[a]),
      .out_c0    (dv_c0[a])
    );
  end

  // Round to nearest, ties away from zero: (2n/d + 1) / 2 on magnitudes.
  logic                 r1_vld_r, r2_vld_r;
  logic [QB-1:0]        r1_q_r [2];
  logic [1:0]           r1_ovf_r, r2_ovf_r;
  tauv_pkg::axis_ctl_t  r1_ctl_r [2];
  tauv_pkg::axis_ctl_t  r2_ctl_r [2];
  logic signed [CW-1:0] r1_c0_r [2];
  logic signed [VW-1:0] r2_val_r [2];
  logic [QB:0]          rnd_sum [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rnd_sum[a] = (QB+1)'(dv_quo[a]) + (QB+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
    end else begin
      r1_vld_r <= dv_valid[0];
      r2_vld_r <= r1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      r1_q_r[a]   <= rnd_sum[a][QB:1];
      r1_ovf_r[a] <= dv_ovf[a];
      r1_ctl_r[a] <= dv_ctl[a];
      r1_c0_r[a]  <= dv_c0[a];
    end
  end

  // Add the signed quotient to the corner 0 parameter.
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      r2_val_r[a] <= r1_ctl_r[a].neg ? VW'(r1_c0_r[a]) - $signed({1'b0, r1_q_r[a]})
                                     : VW'(r1_c0_r[a]) + $signed({1'b0, r1_q_r[a]});
      r2_ovf_r[a] <= r1_ovf_r[a];
      r2_ctl_r[a] <= r1_ctl_r[a];
    end
  end

  // Clip to the word range; collinear corners force zero.
  logic [1:0]    over, under, clip_nxt;
  logic [CW-1:0] res_nxt [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      over[a]  = r2_ovf_r[a] ? !r2_ctl_r[a].neg : (r2_val_r[a] > HI_LIM);
      under[a] = r2_ovf_r[a] ?  r2_ctl_r[a].neg : (r2_val_r[a] < LO_LIM);
      if (r2_ctl_r[a].deg) begin
        res_nxt[a] = '0;
      end else if (over[a]) begin
        res_nxt[a] = OUT_MAX;
      end else if (under[a]) begin
        res_nxt[a] = OUT_MIN;
      end else begin
        res_nxt[a] = r2_val_r[a][CW-1:0];
      end
      clip_nxt[a] = !r2_ctl_r[a].deg && (over[a] || under[a]);
    end
  end

  logic                 out_valid_r;
  logic signed [CW-1:0] out_u_r, out_v_r;
  logic                 out_deg_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= r2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_u_r   <= res_nxt[0];
    out_v_r   <= res_nxt[1];
    out_deg_r <= r2_ctl_r[0].deg;
    out_sat_r <= clip_nxt[0] || clip_nxt[1];
  end

  assign out_valid      = out_valid_r;
  assign out_param_u    = out_u_r;
  assign out_param_v    = out_v_r;
  assign out_degenerate = out_deg_r;
  assign out_saturated  = out_sat_r;

  // Collinear corners give zero parameters and no clipping.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_param_u == '0 && out_param_v == '0 && !out_saturated)
    else $error("degenerate word carries nonzero result");

  // A clipped word has at least one parameter at a range limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_param_u == OUT_MAX || out_param_u == OUT_MIN ||
      out_param_v == OUT_MAX || out_param_v == OUT_MIN)
    else $error("saturated word without a clipped parameter");

  // Both divider lanes stay in lockstep.
  assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid[0] == dv_valid[1])
    else $error("divider lanes out of step");

endmodule

`default_nettype wire

>>> sim/triangle_affine_uv_map_core_tb.sv
// ----------------------------------------------------------------------------
// triangle_affine_uv_map_core_tb: self-checking bench for the UV mapper
// Loads corner positions and UV parameters through the write port, streams
// points and compares every result word against an exact wide-integer
// solve of the affine map, with rounding, clipping and collinear corners.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_affine_uv_map_core_tb;

  localparam int CB = 32;
  // Indexes past the last corner register; writes there must be ignored.
  localparam logic [tauv_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [tauv_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic signed [127:0] WORD_MAX = 128'sh7fff_ffff;
  localparam logic signed [127:0] WORD_MIN = -128'sh8000_0000;
  localparam logic signed [127:0] QUOT_CAP = 128'sh100_0000_0000;
  localparam int ONE = 32'h0001_0000;

  typedef struct packed {
    logic signed [CB-1:0] u;
    logic signed [CB-1:0] v;
    logic                 deg;
    logic                 sat;
  } uv_word_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic signed [CB-1:0]        in_point_x = '0;
  logic signed [CB-1:0]        in_point_y = '0;
  logic                        out_valid;
  logic signed [CB-1:0]        out_param_u;
  logic signed [CB-1:0]        out_param_v;
  logic                        out_degenerate;
  logic                        out_saturated;
  logic                        cfg_we = 1'b0;
  logic [tauv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [2*CB-1:0]             cfg_wdata = '0;

  // Local copy of the corner registers and the queue of pending UV words.
  logic [2*CB-1:0] corner_pos [3];
  logic [2*CB-1:0] corner_uv [3];
  uv_word_t        pending_uv [$];
  int              mismatches = 0;
  int              gap_pct = 0;

  triangle_affine_uv_map_core #(.COORD_BITS(CB)) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .out_valid     (out_valid),
    .out_param_u   (out_param_u),
    .out_param_v   (out_param_v),
    .out_degenerate(out_degenerate),
    .out_saturated (out_saturated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  // One axis: c0 + round(numerator / det), quotient capped, then clipped.
  function automatic logic signed [CB-1:0] solve_axis(
    input logic signed [127:0] c0, c1, c2, s, t, det, inout logic clip);
    logic signed [127:0] num, nm, dm, quo, rem, val;
    logic                neg;
    num = (c1 - c0) * s + (c2 - c0) * t;
    neg = num[127] ^ det[127];
    nm = num[127] ? -num : num;
    dm = det[127] ? -det : det;
    quo = nm / dm;
    rem = nm % dm;
    if (2 * rem >= dm) quo = quo + 1;
    if (quo > QUOT_CAP) quo = QUOT_CAP;
    val = neg ? c0 - quo : c0 + quo;
    if (val > WORD_MAX) begin
      val = WORD_MAX;
      clip = 1'b1;
    end
    if (val < WORD_MIN) begin
      val = WORD_MIN;
      clip = 1'b1;
    end
    return val[CB-1:0];
  endfunction

  // Expected UV word for one point under the current corner registers.
  function automatic uv_word_t map_point(input logic signed [CB-1:0] px, py);
    logic signed [127:0] x0, y0, ax, ay, bx, by, qx, qy, det, s, t;
    uv_word_t            r;
    logic                clip;
    x0 = $signed(corner_pos[0][63:32]);
    y0 = $signed(corner_pos[0][31:0]);
    ax = $signed(corner_pos[1][63:32]) - x0;
    ay = $signed(corner_pos[1][31:0]) - y0;
    bx = $signed(corner_pos[2][63:32]) - x0;
    by = $signed(corner_pos[2][31:0]) - y0;
    qx = px - x0;
    qy = py - y0;
    det = ax * by - bx * ay;
    r = '0;
    clip = 1'b0;
    if (det == 0) begin
      r.deg = 1'b1;
      return r;
    end
    s = qx * by - qy * bx;
    t = ax * qy - ay * qx;
    r.u = solve_axis($signed(corner_uv[0][63:32]), $signed(corner_uv[1][63:32]),
                     $signed(corner_uv[2][63:32]), s, t, det, clip);
    r.v = solve_axis($signed(corner_uv[0][31:0]), $signed(corner_uv[1][31:0]),
                     $signed(corner_uv[2][31:0]), s, t, det, clip);
    r.sat = clip;
    return r;
  endfunction

  // Compare each result word with the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_uv.size() == 0) begin
        $error("unexpected result word u=%0d v=%0d", out_param_u, out_param_v);
        mismatches++;
      end else begin
        uv_word_t e;
        e = pending_uv.pop_front();
        if (out_param_u !== e.u) begin
          $error("param_u expected %0d got %0d", e.u, out_param_u);
          mismatches++;
        end
        if (out_param_v !== e.v) begin
          $error("param_v expected %0d got %0d", e.v, out_param_v);
          mismatches++;
        end
        if (out_degenerate !== e.deg) begin
          $error("degenerate expected %0b got %0b", e.deg, out_degenerate);
          mismatches++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %0b got %0b", e.sat, out_saturated);
          mismatches++;
        end
      end
    end
  end

  // Write one register; called right after a rising edge with start low.
  // The enable drops for one cycle after each write.
  task automatic write_reg(input logic [tauv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tauv_pkg::REG_CORNER0_XY: corner_pos[0] = data;
      tauv_pkg::REG_CORNER1_XY: corner_pos[1] = data;
      tauv_pkg::REG_CORNER2_XY: corner_pos[2] = data;
      tauv_pkg::REG_CORNER0_UV: corner_uv[0] = data;
      tauv_pkg::REG_CORNER1_UV: corner_uv[1] = data;
      tauv_pkg::REG_CORNER2_UV: corner_uv[2] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until the pipeline has drained before touching the registers.
  task automatic drain();
    start <= 1'b0;
    while (pending_uv.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_triangle(input logic [63:0] p0, p1, p2, w0, w1, w2);
    drain();
    write_reg(tauv_pkg::REG_CORNER0_XY, p0);
    write_reg(tauv_pkg::REG_CORNER1_XY, p1);
    write_reg(tauv_pkg::REG_CORNER2_XY, p2);
    write_reg(tauv_pkg::REG_CORNER0_UV, w0);
    write_reg(tauv_pkg::REG_CORNER1_UV, w1);
    write_reg(tauv_pkg::REG_CORNER2_UV, w2);
  endtask

  // Send one point word, with a random gap before it at the current rate.
  task automatic send_point(input logic [CB-1:0] px, py);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (busy);
    pending_uv.insert(pending_uv.size(), map_point(px, py));
  endtask

  function automatic logic [63:0] pack2(input int hi, input int lo);
    return {hi[31:0], lo[31:0]};
  endfunction

  // Reset registers, unit and skewed triangles, rounding ties and clipping.
  task automatic test_directed();
    send_point(32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    load_triangle(pack2(0, 0), pack2(ONE, 0), pack2(0, ONE),
                  pack2(0, 0), pack2(ONE, 0), pack2(0, ONE));
    send_point(0, 0);
    send_point(ONE, 0);
    send_point(0, ONE);
    send_point(ONE / 3, ONE / 5);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'h0000_0001);
    // Half-unit quotients in both signs check ties round away from zero.
    load_triangle(pack2(0, 0), pack2(2, 0), pack2(0, 1),
                  pack2(0, 0), pack2(1, 1), pack2(0, 0));
    send_point(1, 0);
    send_point(-1, 0);
    send_point(3, 7);
    send_point(-3, -2);
    // Swapped corners give a negative determinant.
    load_triangle(pack2(0, 1), pack2(2, 0), pack2(0, 0),
                  pack2(32'h7fff_ffff, 32'h8000_0000), pack2(-5, 5), pack2(7, -7));
    send_point(1, 0);
    send_point(-1, 1);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    // Extreme corners, plus collinear corners and ignored indexes.
    load_triangle(pack2(32'h8000_0000, 32'h8000_0000), pack2(32'h7fff_ffff, 32'h8000_0000),
                  pack2(32'h8000_0000, 32'h7fff_ffff), 64'h7fff_ffff_8000_0000,
                  64'h8000_0000_7fff_ffff, 64'hffff_ffff_ffff_ffff);
    send_point(0, 0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    load_triangle(pack2(0, 0), pack2(ONE, ONE), pack2(2 * ONE, 2 * ONE),
                  pack2(1, 2), pack2(3, 4), pack2(5, 6));
    write_reg(REG_SPARE_A, 64'hdead_beef_dead_beef);
    write_reg(REG_SPARE_B, 64'hffff_ffff_ffff_ffff);
    send_point(ONE, 0);
    send_point(32'h8000_0000, 32'h7fff_ffff);
  endtask

  function automatic int near_coord(input int base);
    return base + $signed($urandom_range(0, 2 * 200 * ONE) - 200 * ONE);
  endfunction

  // Random triangles, each followed by a batch of random points.
  task automatic test_random(input int pct, input int batches);
    logic [63:0] p [3];
    logic [63:0] w [3];
    int          kind, n, k;
    gap_pct = pct;
    for (int b = 0; b < batches; b++) begin
      kind = $urandom_range(9);
      for (int c = 0; c < 3; c++) begin
        p[c] = (kind < 2) ? {$urandom, $urandom} : pack2(near_coord(0), near_coord(0));
        w[c] = (kind == 2) ? {$urandom, $urandom} : pack2(near_coord(0), near_coord(0));
      end
      if (kind == 3) begin
        // Third corner on the line through the other two.
        k = $signed($urandom_range(0, 6)) - 3;
        p[2] = pack2($signed(p[0][63:32]) + k * ($signed(p[1][63:32]) - $signed(p[0][63:32])),
                     $signed(p[0][31:0]) + k * ($signed(p[1][31:0]) - $signed(p[0][31:0])));
      end
      if (kind == 4) p[2] = p[$urandom_range(1)];
      load_triangle(p[0], p[1], p[2], w[0], w[1], w[2]);
      n = $urandom_range(20, 40);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(2);
        if ($urandom_range(3) == 0) send_point($urandom, $urandom);
        else send_point(near_coord($signed(p[k][63:32])), near_coord($signed(p[k][31:0])));
      end
    end
  endtask

  initial begin
    for (int c = 0; c < 3; c++) begin
      corner_pos[c] = '0;
      corner_uv[c] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(11, 10);
    test_random(88, 10);
    test_random(0, 10);
    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("triangle_affine_uv_map_core_tb: PASS");
    else $display("triangle_affine_uv_map_core_tb: FAIL");
    $finish;
  end

  // Run limit well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("triangle_affine_uv_map_core_tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tauv_pkg.sv
rtl/core/tauv_front.sv
rtl/core/tauv_div.sv
rtl/core/triangle_affine_uv_map_core.sv
sim/triangle_affine_uv_map_core_tb.sv
